// ----- sv/psf_pkg.sv -----
// ----------------------------------------------------------------------------
// psf_pkg
// Types and fixed widths shared by the plastic spring force block.
// ----------------------------------------------------------------------------
package psf_pkg;

   localparam int POS_W   = 32;          // position field width
   localparam int DIFF_W  = POS_W + 1;   // difference of two positions
   localparam int SUMSQ_W = 2 * DIFF_W;  // sum of three squares fits here
   localparam int LEN_W   = DIFF_W;      // floor of the square root
   localparam int MUL_W   = 64;          // serial multiplier operand width
   localparam int PROD_W  = 2 * MUL_W;
   localparam int STEP_W  = 7;

   localparam logic [MUL_W-1:0] CAP_BIG = 64'h4000_0000_0000_0000;

   localparam logic [1:0] REG_SPRING_CONSTANT = 2'd0;
   localparam logic [1:0] REG_PLASTIC_FACTOR  = 2'd1;
   localparam logic [1:0] REG_LINK_THRESHOLD  = 2'd2;

   localparam logic OP_SETUP = 1'b0;
   localparam logic OP_APPLY = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SQUARE = 7'b0000010,
      ST_ROOT   = 7'b0000100,
      ST_AMT    = 7'b0001000,
      ST_GAIN   = 7'b0010000,
      ST_DIV    = 7'b0100000,
      ST_FMUL   = 7'b1000000
   } psf_state_type;

   typedef struct packed {
      logic              go;
      logic [STEP_W-1:0] steps;
      logic [MUL_W-1:0]  a;
      logic [MUL_W-1:0]  b;      // multiplier bits, left aligned
   } psf_mul_cmd_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] product;
   } psf_mul_rsp_type;

endpackage

// ----- sv/psf_mul.sv -----
// ----------------------------------------------------------------------------
// psf_mul
// Bit-serial multiplier: one multiplier bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module psf_mul import psf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  psf_mul_cmd_type cmd,
   output psf_mul_rsp_type rsp
);

   logic [MUL_W-1:0]  a_ff, a_in;
   logic [MUL_W-1:0]  b_ff, b_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (cmd.go) begin
         a_in   = cmd.a;
         b_in   = cmd.b;
         acc_in = '0;
         cnt_in = cmd.steps;
         run_in = 1'b1;
      end else if (run_ff) begin
         acc_in = {acc_ff[PROD_W-2:0], 1'b0} + (b_ff[MUL_W-1] ? PROD_W'(a_ff) : '0);
         b_in   = {b_ff[MUL_W-2:0], 1'b0};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

endmodule

// ----- sv/psf_root.sv -----
// ----------------------------------------------------------------------------
// psf_root
// Restoring integer square root, two radicand bits and one root bit a cycle.
// ----------------------------------------------------------------------------
module psf_root import psf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic [SUMSQ_W-1:0] radicand,
   output logic               done,
   output logic [LEN_W-1:0]   root
);

   localparam int CNT_W = $clog2(LEN_W + 1);

   logic [SUMSQ_W-1:0] rad_ff, rad_in;
   logic [LEN_W+1:0]   rem_ff, rem_in;
   logic [LEN_W-1:0]   root_ff, root_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [LEN_W+3:0]   work;
   logic [LEN_W+3:0]   trial;

   always_comb begin
      work    = {rem_ff, rad_ff[SUMSQ_W-1 -: 2]};
      trial   = (LEN_W+4)'({root_ff, 2'b01});
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (go) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(LEN_W);
         run_in  = 1'b1;
      end else if (run_ff) begin
         rad_in = {rad_ff[SUMSQ_W-3:0], 2'b00};
         if (work >= trial) begin
            rem_in  = (LEN_W+2)'(work - trial);
            root_in = {root_ff[LEN_W-2:0], 1'b1};
         end else begin
            rem_in  = (LEN_W+2)'(work);
            root_in = {root_ff[LEN_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- sv/psf_div.sv -----
// ----------------------------------------------------------------------------
// psf_div
// Restoring divider for the unit vector, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module psf_div import psf_pkg::*; #(
   parameter int Q_W = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [LEN_W-1:0] num,
   input  logic [LEN_W-1:0] den,
   output logic             done,
   output logic [Q_W-1:0]   quo
);

   localparam int CNT_W = $clog2(Q_W + 1);

   // The numerator never exceeds the divisor, so the quotient of
   // num * 2^(Q_W-1) / den needs only Q_W bits.
   logic [LEN_W:0]   rem_ff, rem_in;
   logic [LEN_W-1:0] den_ff, den_in;
   logic [Q_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [LEN_W:0]   part;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      part    = rem_ff;
      if (go) begin
         rem_in = {1'b0, num};
         den_in = den;
         quo_in = '0;
         cnt_in = CNT_W'(Q_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (rem_ff >= {1'b0, den_ff}) begin
            part   = rem_ff - {1'b0, den_ff};
            quo_in = {quo_ff[Q_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[Q_W-2:0], 1'b0};
         end
         rem_in = {part[LEN_W-1:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ----- sv/plastic_spring_force.sv -----
// ----------------------------------------------------------------------------
// plastic_spring_force
// Plastic spring table: set-up records a rest length, apply returns the force
// on the second particle and lets the rest length creep towards the stretch.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  request   start / busy          req_opcode, req_slot, req_first_*, req_second_*
//  result    rsp_valid (strobe)    rsp_accepted, rsp_force_*, rsp_saturated
//  config    psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// One item at a time. The three squares, the root, the gain products and the
// three divide/multiply pairs all run bit-serially on one multiplier, one root
// unit and one divider; set-up stops after the root. The result strobe lasts
// one cycle and busy falls with it. Reset is synchronous; the rest-length
// memory is not cleared.
// ----------------------------------------------------------------------------
module plastic_spring_force import psf_pkg::*; #(
   parameter int NUM_SPRINGS = 1024,
   parameter int FRAC_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [9:0]  req_slot,
   input  logic signed [31:0] req_first_x,
   input  logic signed [31:0] req_first_y,
   input  logic signed [31:0] req_first_z,
   input  logic signed [31:0] req_second_x,
   input  logic signed [31:0] req_second_y,
   input  logic signed [31:0] req_second_z,
   output logic        rsp_valid,
   output logic        rsp_accepted,
   output logic signed [31:0] rsp_force_x,
   output logic signed [31:0] rsp_force_y,
   output logic signed [31:0] rsp_force_z,
   output logic        rsp_saturated,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IDX_W = (NUM_SPRINGS > 1) ? $clog2(NUM_SPRINGS) : 1;
   localparam int Q_W   = FRAC_BITS + 1;

   function automatic logic [DIFF_W-1:0] pos_diff(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
      return {a[POS_W-1], a} - {b[POS_W-1], b};
   endfunction

   function automatic logic [DIFF_W-1:0] mag_of(input logic [DIFF_W-1:0] v);
      return v[DIFF_W-1] ? DIFF_W'(-v) : v;
   endfunction

   // configuration
   logic [31:0] spring_constant_ff, plastic_factor_ff, link_threshold_ff;
   logic        cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         spring_constant_ff <= 32'd65536;
         plastic_factor_ff  <= 32'd0;
         link_threshold_ff  <= 32'd65536;
      end else if (cfg_write) begin
         case (paddr[3:2])
            REG_SPRING_CONSTANT: spring_constant_ff <= pwdata;
            REG_PLASTIC_FACTOR:  plastic_factor_ff  <= pwdata;
            REG_LINK_THRESHOLD:  link_threshold_ff  <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_SPRING_CONSTANT: prdata = spring_constant_ff;
         REG_PLASTIC_FACTOR:  prdata = plastic_factor_ff;
         REG_LINK_THRESHOLD:  prdata = link_threshold_ff;
         default:             prdata = '0;
      endcase
   end

   // sequencer registers
   psf_state_type     state_ff, state_in;
   logic              op_ff, op_in;
   logic [9:0]        slot_ff, slot_in;
   logic [DIFF_W-1:0] d_ff [3];
   logic [DIFF_W-1:0] d_in [3];
   logic [1:0]        axis_ff, axis_in;
   logic [SUMSQ_W-1:0] sum_ff, sum_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              negd_ff, negd_in;
   logic [MUL_W-1:0]  amt_ff, amt_in;
   logic [MUL_W-1:0]  gain_ff, gain_in;
   logic [31:0]       force_ff [2];
   logic [31:0]       force_in [2];
   logic              sat_ff, sat_in;
   psf_mul_cmd_type   mul_cmd_ff, mul_cmd_in;
   logic              root_go_ff, root_go_in;
   logic              div_go_ff, div_go_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_accepted_ff, rsp_accepted_in;
   logic [31:0]       rsp_fx_ff, rsp_fx_in, rsp_fy_ff, rsp_fy_in, rsp_fz_ff, rsp_fz_in;
   logic              rsp_sat_ff, rsp_sat_in;

   // unit results
   psf_mul_rsp_type   mul_rsp;
   logic              root_done, div_done;
   logic [LEN_W-1:0]  root_val;
   logic [Q_W-1:0]    quo;

   // rest-length memory
   logic [31:0]       rest_mem [NUM_SPRINGS];
   logic [31:0]       rest_rd_ff;
   logic [IDX_W-1:0]  slot_idx;
   logic              slot_ok;
   logic              mem_we;
   logic [31:0]       mem_wdata;
   logic [16:0]       slot_wide;

   assign slot_wide = {7'b0, slot_ff};
   assign slot_idx  = slot_wide[IDX_W-1:0];
   assign slot_ok   = slot_wide < 17'(NUM_SPRINGS);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rest_mem[slot_idx] <= mem_wdata;
      end
      rest_rd_ff <= rest_mem[slot_idx];
   end

   // working values
   logic [DIFF_W-1:0] mag [3];
   logic [DIFF_W-1:0] mag_cur, mag_next, d_cur;
   logic [DIFF_W-1:0] dx_new;
   logic              ordered;
   logic [LEN_W:0]    delta;
   logic [LEN_W-1:0]  delta_mag;
   logic [PROD_W-1:0] scaled;
   logic [PROD_W-1:0] fscaled;
   logic [MUL_W-1:0]  fmag;
   logic              fneg, fzero;
   logic [31:0]       fval;
   logic              fsat;
   logic [32:0]       rest_sum;
   logic [31:0]       rest_new;
   logic              rest_sat;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag[i] = mag_of(d_ff[i]);
      end
      case (axis_ff)
         2'd0:    begin mag_cur = mag[0]; mag_next = mag[1]; d_cur = d_ff[0]; end
         2'd1:    begin mag_cur = mag[1]; mag_next = mag[2]; d_cur = d_ff[1]; end
         default: begin mag_cur = mag[2]; mag_next = mag[0]; d_cur = d_ff[2]; end
      endcase
   end

   assign dx_new  = pos_diff(req_first_x, req_second_x);
   assign ordered = (!d_ff[0][DIFF_W-1] && d_ff[0] != '0)
                 || (d_ff[0] == '0 && !d_ff[1][DIFF_W-1] && d_ff[1] != '0)
                 || (d_ff[0] == '0 && d_ff[1] == '0
                     && !d_ff[2][DIFF_W-1] && d_ff[2] != '0);
   assign delta     = {1'b0, root_val} - (LEN_W+1)'(rest_rd_ff);
   assign delta_mag = delta[LEN_W] ? LEN_W'(-delta) : delta[LEN_W-1:0];

   // force component from the product of the unit vector and the gain
   always_comb begin
      fscaled = mul_rsp.product >> Q_W;
      fmag    = fscaled[MUL_W-1:0];
      fneg    = d_cur[DIFF_W-1] ^ negd_ff;
      fzero   = (mag_cur == '0) || (len_ff == '0);
      fsat    = 1'b0;
      if (fzero) begin
         fval = '0;
      end else if (fneg) begin
         if (fmag > 64'h8000_0000) begin
            fval = 32'h8000_0000;
            fsat = 1'b1;
         end else begin
            fval = 32'(-fmag[31:0]);
         end
      end else if (fmag > 64'h7FFF_FFFF) begin
         fval = 32'h7FFF_FFFF;
         fsat = 1'b1;
      end else begin
         fval = fmag[31:0];
      end
   end

   // updated rest length, clamped to the unsigned 32-bit range
   always_comb begin
      rest_sum = 33'(rest_rd_ff) + 33'(amt_ff[31:0]);
      rest_sat = 1'b0;
      if (negd_ff) begin
         if (amt_ff > MUL_W'(rest_rd_ff)) begin
            rest_new = '0;
            rest_sat = 1'b1;
         end else begin
            rest_new = rest_rd_ff - amt_ff[31:0];
         end
      end else if (amt_ff[MUL_W-1:32] != '0 || rest_sum[32]) begin
         rest_new = 32'hFFFF_FFFF;
         rest_sat = 1'b1;
      end else begin
         rest_new = rest_sum[31:0];
      end
   end

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      slot_in         = slot_ff;
      d_in            = d_ff;
      axis_in         = axis_ff;
      sum_in          = sum_ff;
      len_in          = len_ff;
      negd_in         = negd_ff;
      amt_in          = amt_ff;
      gain_in         = gain_ff;
      force_in        = force_ff;
      sat_in          = sat_ff;
      mul_cmd_in      = mul_cmd_ff;
      mul_cmd_in.go   = 1'b0;
      root_go_in      = 1'b0;
      div_go_in       = 1'b0;
      rsp_valid_in    = 1'b0;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_fx_in       = rsp_fx_ff;
      rsp_fy_in       = rsp_fy_ff;
      rsp_fz_in       = rsp_fz_ff;
      rsp_sat_in      = rsp_sat_ff;
      mem_we          = 1'b0;
      mem_wdata       = rest_new;
      scaled          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_opcode;
               slot_in  = req_slot;
               d_in[0]  = dx_new;
               d_in[1]  = pos_diff(req_first_y, req_second_y);
               d_in[2]  = pos_diff(req_first_z, req_second_z);
               axis_in  = 2'd0;
               sum_in   = '0;
               sat_in   = 1'b0;
               mul_cmd_in.go    = 1'b1;
               mul_cmd_in.steps = STEP_W'(DIFF_W);
               mul_cmd_in.a     = MUL_W'(mag_of(dx_new));
               mul_cmd_in.b     = {mag_of(dx_new), (MUL_W-DIFF_W)'(0)};
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mul_rsp.done) begin
               sum_in = sum_ff + mul_rsp.product[SUMSQ_W-1:0];
               if (axis_ff == 2'd2) begin
                  root_go_in = 1'b1;
                  state_in   = ST_ROOT;
               end else begin
                  axis_in          = axis_ff + 2'd1;
                  mul_cmd_in.go    = 1'b1;
                  mul_cmd_in.steps = STEP_W'(DIFF_W);
                  mul_cmd_in.a     = MUL_W'(mag_next);
                  mul_cmd_in.b     = {mag_next, (MUL_W-DIFF_W)'(0)};
               end
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               len_in = root_val;
               if (op_ff == OP_SETUP) begin
                  rsp_valid_in    = 1'b1;
                  rsp_accepted_in = slot_ok && ordered
                                 && (root_val < LEN_W'(link_threshold_ff));
                  rsp_fx_in  = '0;
                  rsp_fy_in  = '0;
                  rsp_fz_in  = '0;
                  rsp_sat_in = 1'b0;
                  mem_we     = rsp_accepted_in;
                  mem_wdata  = root_val[31:0];
                  state_in   = ST_IDLE;
               end else if (!slot_ok || delta == '0) begin
                  rsp_valid_in    = 1'b1;
                  rsp_accepted_in = 1'b0;
                  rsp_fx_in  = '0;
                  rsp_fy_in  = '0;
                  rsp_fz_in  = '0;
                  rsp_sat_in = 1'b0;
                  state_in   = ST_IDLE;
               end else begin
                  negd_in          = delta[LEN_W];
                  mul_cmd_in.go    = 1'b1;
                  mul_cmd_in.steps = STEP_W'(32);
                  mul_cmd_in.a     = MUL_W'(delta_mag);
                  mul_cmd_in.b     = {plastic_factor_ff, 32'b0};
                  state_in         = ST_AMT;
               end
            end
         end
         ST_AMT: begin
            if (mul_rsp.done) begin
               scaled           = mul_rsp.product >> FRAC_BITS;
               amt_in           = scaled[MUL_W-1:0];
               mul_cmd_in.go    = 1'b1;
               mul_cmd_in.steps = STEP_W'(32);
               mul_cmd_in.a     = scaled[MUL_W-1:0];
               mul_cmd_in.b     = {spring_constant_ff, 32'b0};
               state_in         = ST_GAIN;
            end
         end
         ST_GAIN: begin
            if (mul_rsp.done) begin
               scaled    = mul_rsp.product >> FRAC_BITS;
               gain_in   = (scaled > PROD_W'(CAP_BIG)) ? CAP_BIG : scaled[MUL_W-1:0];
               axis_in   = 2'd0;
               div_go_in = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               mul_cmd_in.go    = 1'b1;
               mul_cmd_in.steps = STEP_W'(Q_W);
               mul_cmd_in.a     = gain_ff;
               mul_cmd_in.b     = MUL_W'(quo) << (MUL_W - Q_W);
               state_in         = ST_FMUL;
            end
         end
         ST_FMUL: begin
            if (mul_rsp.done) begin
               sat_in = sat_ff | fsat;
               if (axis_ff == 2'd2) begin
                  rsp_valid_in    = 1'b1;
                  rsp_accepted_in = 1'b0;
                  rsp_fx_in  = force_ff[0];
                  rsp_fy_in  = force_ff[1];
                  rsp_fz_in  = fval;
                  rsp_sat_in = sat_ff | fsat | rest_sat;
                  mem_we     = 1'b1;
                  mem_wdata  = rest_new;
                  state_in   = ST_IDLE;
               end else begin
                  force_in[axis_ff[0]] = fval;
                  axis_in   = axis_ff + 2'd1;
                  div_go_in = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mul_cmd_ff.go <= 1'b0;
         root_go_ff    <= 1'b0;
         div_go_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mul_cmd_ff.go <= mul_cmd_in.go;
         root_go_ff    <= root_go_in;
         div_go_ff     <= div_go_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mul_cmd_ff.steps <= mul_cmd_in.steps;
      mul_cmd_ff.a     <= mul_cmd_in.a;
      mul_cmd_ff.b     <= mul_cmd_in.b;
      op_ff    <= op_in;
      slot_ff  <= slot_in;
      d_ff     <= d_in;
      axis_ff  <= axis_in;
      sum_ff   <= sum_in;
      len_ff   <= len_in;
      negd_ff  <= negd_in;
      amt_ff   <= amt_in;
      gain_ff  <= gain_in;
      force_ff <= force_in;
      sat_ff   <= sat_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_fx_ff  <= rsp_fx_in;
      rsp_fy_ff  <= rsp_fy_in;
      rsp_fz_ff  <= rsp_fz_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   psf_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd_ff),
      .rsp   (mul_rsp)
   );

   psf_root u_root (
      .clock    (clock),
      .reset    (reset),
      .go       (root_go_ff),
      .radicand (sum_ff),
      .done     (root_done),
      .root     (root_val)
   );

   psf_div #(.Q_W(Q_W)) u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go_ff),
      .num   (mag_cur),
      .den   (len_ff),
      .done  (div_done),
      .quo   (quo)
   );

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accepted  = rsp_accepted_ff;
   assign rsp_force_x   = rsp_fx_ff;
   assign rsp_force_y   = rsp_fy_ff;
   assign rsp_force_z   = rsp_fz_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule
